[hdl/prm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package prm_pkg;

   localparam int WINDOW_DEPTH        = 64;
   localparam int ANALYSIS_PERIOD     = 32;
   localparam int DEF_FRAME_PERIOD    = 4;
   localparam int DEF_SAMPLE_BITS     = 12;

   localparam int BAR_FIRST           = 35;
   localparam int BAR_STRIDE          = 4;
   localparam int BAR_LANES           = 8;
   localparam int START_LIMIT         = 51;
   localparam int END_LIMIT           = 62;
   localparam int END_GAP             = 10;
   localparam int DIGIT_MAX           = 99;
   localparam int FRAME_ROWS          = 8;

   localparam int THRESHOLD_BITS      = 12;
   localparam int NUMERATOR_BITS      = 16;
   localparam int BPM_BITS            = 8;
   localparam int IDX_BITS            = 6;

   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 12'd205;
   localparam logic [NUMERATOR_BITS-1:0] NUMERATOR_RESET = 16'd1920;

   localparam logic CSR_EDGE_THRESHOLD = 1'b0;
   localparam logic CSR_RATE_NUMERATOR = 1'b1;

   typedef struct packed {
      logic [11:0] sample;
      logic        bar_mode;
   } req_type;

   typedef struct packed {
      logic [3:0] row_address;
      logic [7:0] row_bits;
      logic       last_row;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_BAR   = 6'b000010,
      S_EMIT  = 6'b000100,
      S_WRITE = 6'b001000,
      S_SCAN  = 6'b010000,
      S_DIV   = 6'b100000
   } state_type;

   // font rows packed row 7 down to row 0, one nibble each
   function automatic logic [3:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
      logic [31:0] rows;
      case (digit)
         4'd0: rows = 32'h0EAAAAE0;
         4'd1: rows = 32'h04644440;
         4'd2: rows = 32'h04A842E0;
         4'd3: rows = 32'h0E848A60;
         4'd4: rows = 32'h0AAE8880;
         4'd5: rows = 32'h0E268A60;
         4'd6: rows = 32'h0E2EAAE0;
         4'd7: rows = 32'h0E842220;
         4'd8: rows = 32'h0EAEAAE0;
         4'd9: rows = 32'h0EAE8AE0;
         default: rows = 32'h0;
      endcase
      return rows[{row, 2'b00} +: 4];
   endfunction

   // tens digit of a value below 100 by reciprocal multiply
   function automatic logic [3:0] digit_tens(input logic [6:0] value);
      logic [14:0] prod;
      prod = 15'(value) * 15'd205;
      return prod[14:11];
   endfunction

endpackage

`default_nettype wire

[hdl/prm_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

module prm_divider import prm_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [NUMERATOR_BITS-1:0] numer,
   input  wire logic [IDX_BITS-1:0]       denom,
   output div_stat_type                   stat,
   output logic [NUMERATOR_BITS-1:0]      quotient
);

   logic                      busy_ff;
   logic                      done_ff;
   logic [3:0]                cnt_ff;
   logic [IDX_BITS-1:0]       rem_ff;
   logic [IDX_BITS-1:0]       den_ff;
   logic [NUMERATOR_BITS-1:0] quo_ff;

   logic [IDX_BITS:0]         trial;
   logic                      fits;

   assign trial = {rem_ff, quo_ff[NUMERATOR_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 4'd15;
            rem_ff  <= '0;
            den_ff  <= denom;
            quo_ff  <= numer;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= IDX_BITS'(trial - {1'b0, den_ff});
            end else begin
               rem_ff <= trial[IDX_BITS-1:0];
            end
            quo_ff <= {quo_ff[NUMERATOR_BITS-2:0], fits};
            cnt_ff <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

`default_nettype wire

[hdl/pulse_rate_matrix_display_core.sv]
// one item per req transfer; not ready again until the item is done
// plain tick: IDLE then WRITE; frame tick adds 8 row transfers (and bar-lane window reads in bar mode)
// analysis tick adds a 64-entry window scan and a 16-step divider
// synchronous active-high reset; the window reads as zero until written (fill count, no sweep)
`timescale 1ns / 1ps
`default_nettype none

module pulse_rate_matrix_display_core import prm_pkg::*; #(
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int FRAME_PERIOD = DEF_FRAME_PERIOD
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_we,
   input  wire logic                      csr_index,
   input  wire logic [NUMERATOR_BITS-1:0] csr_wdata
);

   localparam int FCW = (FRAME_PERIOD > 1) ? $clog2(FRAME_PERIOD) : 1;
   localparam int FRAME_RESET = 1 % FRAME_PERIOD;
   localparam int DW = ((SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS) + 2;
   localparam int PW = $clog2(ANALYSIS_PERIOD);
   localparam int CW = IDX_BITS + 1;

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0]    smp_ff;
   logic                      mode_bar_ff;
   logic [IDX_BITS-1:0]       wp_ff;
   logic [CW-1:0]             fill_ff;
   logic [PW-1:0]             phase_ff;
   logic [FCW-1:0]            frame_ff;
   logic [BPM_BITS-1:0]       bpm_ff;
   logic [THRESHOLD_BITS-1:0] thr_ff;
   logic [NUMERATOR_BITS-1:0] num_ff;
   logic [CW-1:0]             cnt_ff;
   logic [2:0]                row_ff;

   logic                      rd_valid_ff;
   logic                      rd_live_ff;
   logic [IDX_BITS-1:0]       rd_idx_ff;
   logic [SAMPLE_BITS-1:0]    mem_q_ff;
   logic [SAMPLE_BITS-1:0]    mem [WINDOW_DEPTH];

   logic [SAMPLE_BITS-1:0]    bar_ff [BAR_LANES];
   logic [SAMPLE_BITS-1:0]    hist1_ff;
   logic [SAMPLE_BITS-1:0]    hist2_ff;
   logic                      start_found_ff;
   logic [IDX_BITS-1:0]       start_ff;
   logic                      end_found_ff;
   logic [IDX_BITS-1:0]       end_ff;
   logic                      div_go_ff;

   logic                      rsp_valid_ff;
   rsp_type                   rsp_data_ff;

   logic                      req_fire;
   logic                      rd_issue;
   logic [IDX_BITS-1:0]       rd_idx;
   logic [IDX_BITS-1:0]       rd_addr;
   logic [CW:0]               live_sum;
   logic [SAMPLE_BITS-1:0]    rd_data;
   logic                      mem_we;
   logic                      emit_load;

   logic [DW-1:0]             rise;
   logic                      is_edge;
   logic [IDX_BITS-1:0]       scan_pos;
   logic [IDX_BITS-1:0]       eff_start;
   logic [IDX_BITS-1:0]       end_val;
   logic [IDX_BITS-1:0]       divisor;

   logic [6:0]                shown;
   logic [3:0]                tens;
   logic [3:0]                ones;
   logic [7:0]                row_bits;
   logic [SAMPLE_BITS-1:0]    row_level;

   div_stat_type              div_stat;
   logic [NUMERATOR_BITS-1:0] div_quo;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // window read port, logical index mapped onto the circular buffer
   always_comb begin
      rd_issue = 1'b0;
      rd_idx   = cnt_ff[IDX_BITS-1:0];
      if (state_ff == S_BAR) begin
         rd_issue = (cnt_ff < CW'(BAR_LANES));
         rd_idx   = IDX_BITS'(BAR_FIRST) + {cnt_ff[2:0], 2'b00};
      end else if (state_ff == S_SCAN) begin
         rd_issue = (cnt_ff < CW'(WINDOW_DEPTH));
      end
   end

   assign rd_addr  = wp_ff + rd_idx;
   assign live_sum = (CW+1)'(rd_idx) + (CW+1)'(fill_ff);
   assign rd_data  = rd_live_ff ? mem_q_ff : '0;
   assign mem_we   = (state_ff == S_WRITE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= smp_ff;
      end
      mem_q_ff <= mem[rd_addr];
   end

   // edge search
   assign rise      = DW'(rd_data) - DW'(hist2_ff);
   assign is_edge   = $signed(rise) >= $signed(DW'(thr_ff));
   assign scan_pos  = rd_idx_ff - IDX_BITS'(2);
   assign eff_start = start_found_ff ? start_ff : IDX_BITS'(START_LIMIT);
   assign end_val   = end_found_ff ? end_ff : IDX_BITS'(END_LIMIT);
   assign divisor   = end_val - eff_start;

   // row formatting
   assign shown     = (bpm_ff > BPM_BITS'(DIGIT_MAX)) ? 7'(DIGIT_MAX) : bpm_ff[6:0];
   assign tens      = digit_tens(shown);
   assign ones      = 4'(shown - 7'(tens) * 7'd10);
   assign row_level = SAMPLE_BITS'(row_ff) << (SAMPLE_BITS - 3);

   always_comb begin
      row_bits = {glyph_row(ones, row_ff), glyph_row(tens, row_ff)};
      if (mode_bar_ff) begin
         for (int k = 0; k < BAR_LANES; k++) begin
            row_bits[k] = bar_ff[k] > row_level;
         end
      end
   end

   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (frame_ff == FCW'(1)) begin
                  state_in = req_data.bar_mode ? S_BAR : S_EMIT;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_BAR: begin
            if (cnt_ff == CW'(BAR_LANES)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_load && row_ff == 3'(FRAME_ROWS - 1)) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            state_in = (phase_ff == '0) ? S_SCAN : S_IDLE;
         end
         S_SCAN: begin
            if (rd_valid_ff && rd_idx_ff == IDX_BITS'(WINDOW_DEPTH - 1)) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         wp_ff          <= '0;
         fill_ff        <= '0;
         phase_ff       <= PW'(1);
         frame_ff       <= FCW'(FRAME_RESET);
         bpm_ff         <= '0;
         thr_ff         <= THRESHOLD_RESET;
         num_ff         <= NUMERATOR_RESET;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         div_go_ff      <= 1'b0;
         start_found_ff <= 1'b0;
         end_found_ff   <= 1'b0;
         cnt_ff         <= '0;
         row_ff         <= '0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_issue;
         rd_live_ff  <= live_sum >= (CW+1)'(WINDOW_DEPTH);
         rd_idx_ff   <= rd_idx;
         div_go_ff   <= 1'b0;

         if (csr_we) begin
            case (csr_index)
               CSR_EDGE_THRESHOLD: thr_ff <= csr_wdata[THRESHOLD_BITS-1:0];
               CSR_RATE_NUMERATOR: num_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (rd_issue) begin
            cnt_ff <= cnt_ff + CW'(1);
         end

         if (req_fire) begin
            smp_ff      <= SAMPLE_BITS'(req_data.sample);
            mode_bar_ff <= req_data.bar_mode;
            cnt_ff      <= '0;
            row_ff      <= '0;
         end

         if (state_ff == S_BAR && rd_valid_ff) begin
            for (int k = 0; k < BAR_LANES - 1; k++) begin
               bar_ff[k] <= bar_ff[k+1];
            end
            bar_ff[BAR_LANES-1] <= rd_data;
         end

         if (emit_load) begin
            rsp_valid_ff             <= 1'b1;
            rsp_data_ff.row_address  <= {1'b0, row_ff} + 4'd1;
            rsp_data_ff.row_bits     <= row_bits;
            rsp_data_ff.last_row     <= (row_ff == 3'(FRAME_ROWS - 1));
            row_ff                   <= row_ff + 3'd1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (mem_we) begin
            wp_ff    <= wp_ff + IDX_BITS'(1);
            if (fill_ff != CW'(WINDOW_DEPTH)) begin
               fill_ff <= fill_ff + CW'(1);
            end
            phase_ff <= (phase_ff == PW'(ANALYSIS_PERIOD - 1)) ? '0 : phase_ff + PW'(1);
            if (phase_ff == PW'(ANALYSIS_PERIOD - 1) || frame_ff == FCW'(FRAME_PERIOD - 1)) begin
               frame_ff <= '0;
            end else begin
               frame_ff <= frame_ff + FCW'(1);
            end
            cnt_ff         <= '0;
            start_found_ff <= 1'b0;
            end_found_ff   <= 1'b0;
         end

         if (state_ff == S_SCAN && rd_valid_ff) begin
            hist1_ff <= rd_data;
            hist2_ff <= hist1_ff;
            if (rd_idx_ff >= IDX_BITS'(2)) begin
               if (!start_found_ff && scan_pos < IDX_BITS'(START_LIMIT) && is_edge) begin
                  start_found_ff <= 1'b1;
                  start_ff       <= scan_pos;
               end
               if (!end_found_ff && scan_pos >= eff_start + IDX_BITS'(END_GAP) && is_edge) begin
                  end_found_ff <= 1'b1;
                  end_ff       <= scan_pos;
               end
            end
            if (rd_idx_ff == IDX_BITS'(WINDOW_DEPTH - 1)) begin
               div_go_ff <= 1'b1;
            end
         end

         if (state_ff == S_DIV && div_stat.done) begin
            bpm_ff <= (|div_quo[NUMERATOR_BITS-1:BPM_BITS]) ? '1 : div_quo[BPM_BITS-1:0];
         end
      end
   end

   prm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .numer    (num_ff),
      .denom    (divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("ready again right after an input transfer");

   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == S_DIV))
      else $error("divider running outside the divide step");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(WINDOW_DEPTH))
      else $error("window fill count overflow");

   a_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.last_row) |-> (rsp_data_ff.row_address == 4'(FRAME_ROWS)))
      else $error("last row flag on wrong row");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (phase_ff == PW'(1)))
      else $error("window scan outside the analysis tick");

endmodule

`default_nettype wire

[sim/pulse_rate_matrix_display_core_test.sv]
`timescale 1ns / 1ps

module pulse_rate_matrix_display_core_test import prm_pkg::*; ();

   localparam int SETTLE_CYCLES = 150;
   localparam int LONG_HOLD     = 400;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we = 1'b0;
   logic                      csr_index = CSR_EDGE_THRESHOLD;
   logic [NUMERATOR_BITS-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_armed = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;
   int settings_used = 0;

   // digit glyphs, row 7 in the top byte down to row 0 in the bottom byte
   function automatic logic [7:0] font_row(input int digit, input int row);
      logic [63:0] rows;
      case (digit)
         0: rows = 64'h000E0A0A0A0A0E00;
         1: rows = 64'h0004060404040400;
         2: rows = 64'h00040A0804020E00;
         3: rows = 64'h000E0804080A0600;
         4: rows = 64'h000A0A0E08080800;
         5: rows = 64'h000E0206080A0600;
         6: rows = 64'h000E020E0A0A0E00;
         7: rows = 64'h000E080402020200;
         8: rows = 64'h000E0A0E0A0A0E00;
         default: rows = 64'h000E0A0E080A0E00;
      endcase
      return rows[8*row +: 8];
   endfunction

   class rate_display_scoreboard;
      logic [11:0]               window [WINDOW_DEPTH];
      logic [4:0]                phase;
      logic [BPM_BITS-1:0]       bpm;
      logic [THRESHOLD_BITS-1:0] threshold;
      logic [NUMERATOR_BITS-1:0] numerator;
      rsp_type                   rows_due [$];
      int errors;
      int samples_taken;
      int rows_checked;
      int frames_due;
      int rate_updates;
      int top_rate;

      function new();
         foreach (window[i]) window[i] = '0;
         phase = 5'd1;
         bpm = '0;
         threshold = THRESHOLD_RESET;
         numerator = NUMERATOR_RESET;
         errors = 0;
         samples_taken = 0;
         rows_checked = 0;
         frames_due = 0;
         rate_updates = 0;
         top_rate = 0;
      endfunction

      function void set_register(input logic idx, input logic [NUMERATOR_BITS-1:0] value);
         if (idx == CSR_EDGE_THRESHOLD)
            threshold = value[THRESHOLD_BITS-1:0];
         else
            numerator = value;
      endfunction

      function bit rises_at(input int i);
         return int'(window[i+2]) - int'(window[i]) >= int'(threshold);
      endfunction

      function void recount_rate();
         int s;
         int e;
         int q;
         s = 0;
         while (s < START_LIMIT && !rises_at(s))
            s++;
         e = s + END_GAP;
         while (e < END_LIMIT && !rises_at(e))
            e++;
         q = int'(numerator) / (e - s);
         bpm = (q > 255) ? 8'd255 : q[7:0];
         rate_updates++;
         if (int'(bpm) > top_rate)
            top_rate = bpm;
      endfunction

      function void accept_sample(input req_type item);
         rsp_type row;
         int shown;
         samples_taken++;
         if (phase % DEF_FRAME_PERIOD == 1) begin
            shown = (bpm > DIGIT_MAX) ? DIGIT_MAX : int'(bpm);
            frames_due++;
            for (int r = 0; r < FRAME_ROWS; r++) begin
               row.row_address = 4'(r + 1);
               row.last_row = (r == FRAME_ROWS - 1);
               row.row_bits = '0;
               if (item.bar_mode) begin
                  for (int k = 0; k < BAR_LANES; k++)
                     if (int'(window[BAR_FIRST + BAR_STRIDE*k]) * 8 > r * 4096)
                        row.row_bits[k] = 1'b1;
               end else begin
                  row.row_bits = 8'(font_row(shown % 10, r) << 4) | font_row(shown / 10, r);
               end
               rows_due.push_back(row);
            end
         end
         for (int i = 0; i < WINDOW_DEPTH - 1; i++)
            window[i] = window[i+1];
         window[WINDOW_DEPTH-1] = item.sample;
         if (phase == 0)
            recount_rate();
         phase = phase + 5'd1;
      endfunction

      function void check_row(input rsp_type got);
         rsp_type want;
         if (rows_due.size() == 0) begin
            $display("%0t unexpected row: got addr %0d bits %02h last %0d",
                     $time, got.row_address, got.row_bits, got.last_row);
            errors++;
            return;
         end
         want = rows_due.pop_front();
         rows_checked++;
         if (got.row_address !== want.row_address) begin
            $display("%0t row_address mismatch: expected %0d, got %0d",
                     $time, want.row_address, got.row_address);
            errors++;
         end
         if (got.row_bits !== want.row_bits) begin
            $display("%0t row_bits mismatch (row %0d): expected %02h, got %02h",
                     $time, want.row_address, want.row_bits, got.row_bits);
            errors++;
         end
         if (got.last_row !== want.last_row) begin
            $display("%0t last_row mismatch (row %0d): expected %0d, got %0d",
                     $time, want.row_address, want.last_row, got.last_row);
            errors++;
         end
      endfunction
   endclass

   rate_display_scoreboard book;

   pulse_rate_matrix_display_core #(
      .SAMPLE_BITS  (DEF_SAMPLE_BITS),
      .FRAME_PERIOD (DEF_FRAME_PERIOD)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // receiver: random stalls, plus one long hold-off
   always @(negedge clock) begin
      if (hold_armed && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         book.check_row(rsp_data);
   end

   task automatic send_item(input logic [11:0] sample, input logic bar);
      req_type item;
      item.sample = sample;
      item.bar_mode = bar;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      book.accept_sample(item);
   endtask

   task automatic csr_write(input logic idx, input logic [NUMERATOR_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      book.set_register(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.rows_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_rates(input int thr, input int num);
      csr_write(CSR_EDGE_THRESHOLD, {4'($urandom), 12'(thr)});
      csr_write(CSR_RATE_NUMERATOR, 16'(num));
      settings_used++;
   endtask

   // mostly pulse trains with random shape, some pure noise and full-scale pulses without jitter
   task automatic run_pulses(input int items);
      int sent;
      int span;
      int period;
      int base;
      int height;
      int jitter;
      int shape;
      int pos;
      int level;
      sent = 0;
      while (sent < items) begin
         span = $urandom_range(20, 70);
         period = $urandom_range(10, 48);
         shape = $urandom_range(9);
         base = $urandom_range(0, 1500);
         height = $urandom_range(0, 4095 - base);
         jitter = $urandom_range(0, 80);
         if (shape == 9) begin
            base = 0;
            height = 4095;
            jitter = 0;
         end
         for (int i = 0; i < span && sent < items; i++) begin
            pos = i % period;
            if (shape < 2)
               level = $urandom_range(0, 4095);
            else if (pos == 0)
               level = base;
            else if (pos == 1)
               level = base + height / 2;
            else if (pos == 2)
               level = base + height;
            else
               level = base + height * (period - pos) / period;
            if (shape != 9)
               level = level + $urandom_range(0, jitter);
            if (level > 4095)
               level = 4095;
            send_item(12'(level), 1'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      book = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 15;
      recv_idle_pct = 81;

      // directed: field extremes and bar thresholds at row boundaries
      send_item(12'd4095, 1'b1);
      send_item(12'd0, 1'b0);
      send_item(12'd512, 1'b1);
      send_item(12'd513, 1'b0);
      send_item(12'd4095, 1'b1);
      for (int i = 0; i < 8; i++)
         send_item(12'(i * 512), 1'b1);
      for (int i = 0; i < 8; i++)
         send_item(12'(i * 512 + 1), 1'(i));
      send_item(12'hAAA, 1'b1);
      send_item(12'h555, 1'b0);
      send_item(12'hFFF, 1'b1);
      drain_and_settle();

      program_rates(205, 1920);
      run_pulses(70);
      drain_and_settle();

      // fast rate with large numerator: saturation and digit clamp
      program_rates(0, 65535);
      run_pulses(40);
      drain_and_settle();

      send_idle_pct = 81;
      recv_idle_pct = 15;
      program_rates(4095, 0);
      run_pulses(40);
      drain_and_settle();

      program_rates($urandom_range(0, 4095), $urandom_range(0, 65535));
      run_pulses(60);
      drain_and_settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_rates($urandom_range(50, 600), 1);
      hold_armed = 1'b1;
      run_pulses(50);
      drain_and_settle();

      program_rates($urandom_range(100, 900), $urandom_range(600, 8000));
      run_pulses(40);
      drain_and_settle();

      $display("covered %0d samples over %0d register settings, %0d frames, %0d rows checked",
               book.samples_taken, settings_used, book.frames_due, book.rows_checked);
      $display("rate recomputed %0d times, highest stored rate %0d, %0d errors",
               book.rate_updates, book.top_rate, book.errors);
      if (book.errors == 0 && book.rows_due.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d rows outstanding", book.rows_due.size());
      $display("status: fail");
      $finish;
   end

endmodule
